### design/priority_sorted_run_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Priority-sorted run queue: assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SORTED_RUN_QUEUE_TOP_MACROS_SVH
`define PRIORITY_SORTED_RUN_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define RSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Constants, codes and control types of the priority-sorted run queue.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int TASK_BITS     = 4;
    localparam int KIND_BITS     = 2;
    localparam int IN_PRIO_BITS  = 8;
    localparam int STATUS_BITS   = 2;
    localparam int OCC_OUT_BITS  = 5;
    localparam int OCC_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_BITS-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_PEEK    = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                   load_req;
        logic                   commit;
        logic                   apply;
        logic [STATUS_BITS-1:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_enq;
        logic is_deq;
        logic is_full;
        logic found;
    } dp_stat_t;

endpackage

### design/rsq_req_if.sv
// ----------------------------------------------------------------------------
// rsq_req_if
// Request channel: operation kind, task id and priority with valid/ready.
// ----------------------------------------------------------------------------
interface rsq_req_if
    import rsq_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [KIND_BITS-1:0]    kind;
    logic [TASK_BITS-1:0]    task_id;
    logic [IN_PRIO_BITS-1:0] task_priority;

    modport source (output valid, kind, task_id, task_priority, input ready);
    modport sink   (input valid, kind, task_id, task_priority, output ready);
endinterface

### design/rsq_rsp_if.sv
// ----------------------------------------------------------------------------
// rsq_rsp_if
// Response channel: head task, idle flag, status and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface rsq_rsp_if
    import rsq_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TASK_BITS-1:0]    head_task;
    logic                    head_is_idle;
    logic [STATUS_BITS-1:0]  status;
    logic [OCC_OUT_BITS-1:0] occupancy;

    modport source (output valid, head_task, head_is_idle, status, occupancy, input ready);
    modport sink   (input valid, head_task, head_is_idle, status, occupancy, output ready);
endinterface

### design/rsq_ctrl.sv
// ----------------------------------------------------------------------------
// rsq_ctrl
// Sequencer: accepts a transaction, lets the datapath settle, commits the
// update and the result register when the response slot is free.
// ----------------------------------------------------------------------------
module rsq_ctrl
    import rsq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd.load_req = 1'b0;
        cmd.commit   = 1'b0;
        cmd.apply    = (stat.is_enq && !stat.is_full) || (stat.is_deq && stat.found);
        if (stat.is_enq && stat.is_full)
        begin
            cmd.code = STATUS_FULL;
        end
        else if (stat.is_deq && !stat.found)
        begin
            cmd.code = STATUS_ABSENT;
        end
        else
        begin
            cmd.code = STATUS_OK;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/rsq_datapath.sv
// ----------------------------------------------------------------------------
// rsq_datapath
// Row of sorted queue cells with parallel compare, shift-in on enqueue and
// shift-out on dequeue, plus request, idle-task and result registers.
// ----------------------------------------------------------------------------
module rsq_datapath
    import rsq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [TASK_BITS-1:0]    cfg_wr_data,
    input  logic [KIND_BITS-1:0]    req_kind,
    input  logic [TASK_BITS-1:0]    req_task,
    input  logic [IN_PRIO_BITS-1:0] req_priority,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    output logic [TASK_BITS-1:0]    head_task,
    output logic                    head_is_idle,
    output logic [STATUS_BITS-1:0]  status,
    output logic [OCC_OUT_BITS-1:0] occupancy
);

    logic [TASK_BITS-1:0]     idle_task_reg;
    logic [KIND_BITS-1:0]     kind_reg;
    logic [TASK_BITS-1:0]     task_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;

    logic [TASK_BITS-1:0]     entry_task_reg [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] entry_prio_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   entry_valid_reg;
    logic [OCC_BITS-1:0]      occ_reg;

    logic [TASK_BITS-1:0]     head_task_reg;
    logic                     head_idle_reg;
    logic [STATUS_BITS-1:0]   status_reg;
    logic [OCC_BITS-1:0]      occ_out_reg;

    logic [QUEUE_DEPTH-1:0]   lt;
    logic [QUEUE_DEPTH-1:0]   lt_prev;
    logic [QUEUE_DEPTH-1:0]   match;
    logic [QUEUE_DEPTH-1:0]   hit_before;
    logic [QUEUE_DEPTH-1:0]   up_valid;
    logic [QUEUE_DEPTH-1:0]   down_valid;
    logic [TASK_BITS-1:0]     up_task    [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] up_prio    [QUEUE_DEPTH];
    logic [TASK_BITS-1:0]     down_task  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] down_prio  [QUEUE_DEPTH];

    logic [TASK_BITS-1:0]     enq_task   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] enq_prio   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   enq_valid;
    logic [TASK_BITS-1:0]     deq_task   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] deq_prio   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   deq_valid;

    logic [OCC_BITS-1:0]      occ_next;
    logic [TASK_BITS-1:0]     new_head;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        assign lt[g]    = entry_valid_reg[g] && (entry_prio_reg[g] < prio_reg);
        assign match[g] = entry_valid_reg[g] && (entry_task_reg[g] == task_reg);

        if (g == 0)
        begin : g_first
            assign lt_prev[g]    = 1'b1;
            assign hit_before[g] = 1'b0;
            assign up_valid[g]   = 1'b1;
            assign up_task[g]    = task_reg;
            assign up_prio[g]    = prio_reg;
        end
        else
        begin : g_rest
            assign lt_prev[g]    = lt[g-1];
            assign hit_before[g] = hit_before[g-1] | match[g-1];
            assign up_valid[g]   = entry_valid_reg[g-1];
            assign up_task[g]    = entry_task_reg[g-1];
            assign up_prio[g]    = entry_prio_reg[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign down_valid[g] = 1'b0;
            assign down_task[g]  = entry_task_reg[g];
            assign down_prio[g]  = entry_prio_reg[g];
        end
        else
        begin : g_inner
            assign down_valid[g] = entry_valid_reg[g+1];
            assign down_task[g]  = entry_task_reg[g+1];
            assign down_prio[g]  = entry_prio_reg[g+1];
        end

        always_comb
        begin
            if (lt[g])
            begin
                enq_task[g] = entry_task_reg[g];
                enq_prio[g] = entry_prio_reg[g];
            end
            else if (lt_prev[g])
            begin
                enq_task[g] = task_reg;
                enq_prio[g] = prio_reg;
            end
            else
            begin
                enq_task[g] = up_task[g];
                enq_prio[g] = up_prio[g];
            end
            enq_valid[g] = entry_valid_reg[g] | up_valid[g];

            if (hit_before[g] || match[g])
            begin
                deq_task[g]  = down_task[g];
                deq_prio[g]  = down_prio[g];
                deq_valid[g] = down_valid[g];
            end
            else
            begin
                deq_task[g]  = entry_task_reg[g];
                deq_prio[g]  = entry_prio_reg[g];
                deq_valid[g] = entry_valid_reg[g];
            end
        end
    end

    assign stat.is_enq  = (kind_reg == KIND_ENQUEUE);
    assign stat.is_deq  = (kind_reg == KIND_DEQUEUE);
    assign stat.is_full = entry_valid_reg[QUEUE_DEPTH-1];
    assign stat.found   = |match;

    always_comb
    begin
        occ_next = occ_reg;
        new_head = entry_task_reg[0];
        if (cmd.apply && stat.is_enq)
        begin
            occ_next = occ_reg + OCC_BITS'(1);
            new_head = enq_task[0];
        end
        else if (cmd.apply && stat.is_deq)
        begin
            occ_next = occ_reg - OCC_BITS'(1);
            new_head = deq_task[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_task_reg   <= '0;
            entry_valid_reg <= '0;
            occ_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                idle_task_reg <= cfg_wr_data;
            end
            if (cmd.commit && cmd.apply)
            begin
                entry_valid_reg <= stat.is_enq ? enq_valid : deq_valid;
                occ_reg         <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= req_kind;
            task_reg <= req_task;
            prio_reg <= PRIORITY_BITS'(req_priority);
        end
        if (cmd.commit && cmd.apply)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                entry_task_reg[i] <= stat.is_enq ? enq_task[i] : deq_task[i];
                entry_prio_reg[i] <= stat.is_enq ? enq_prio[i] : deq_prio[i];
            end
        end
        if (cmd.commit)
        begin
            head_idle_reg <= (occ_next == '0);
            head_task_reg <= (occ_next == '0) ? idle_task_reg : new_head;
            status_reg    <= cmd.code;
            occ_out_reg   <= occ_next;
        end
    end

    assign head_task    = head_task_reg;
    assign head_is_idle = head_idle_reg;
    assign status       = status_reg;
    assign occupancy    = OCC_OUT_BITS'(occ_out_reg);

endmodule

### design/priority_sorted_run_queue_top.sv
// ----------------------------------------------------------------------------
// priority_sorted_run_queue_top
// Run queue kept sorted by ascending priority number, with delete by task id.
//
// req carries one operation per transaction: enqueue (task_id, task_priority),
// dequeue (task_id) or peek. rsp returns one transaction per request with the
// head task after the operation (idle task when empty), the idle flag, a
// status code and the occupancy. cfg_wr_en/cfg_wr_data set the idle task id.
// A request is loaded into the request registers in the idle state; its result
// is registered in the execute state, and no new request is taken before that.
// All cells compare and shift in parallel in the execute state.
// req.ready is high whenever no operation is executing, also while a result
// waits on rsp. If rsp stalls, the next operation waits in its execute cycle
// until the result register frees, and req stays blocked meanwhile.
// Reset empties the queue, clears the idle task id to zero and drops rsp.valid.
// ----------------------------------------------------------------------------
module priority_sorted_run_queue_top
    import rsq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rsq_req_if.sink              req,
    rsq_rsp_if.source            rsp,
    input  logic                 cfg_wr_en,
    input  logic [TASK_BITS-1:0] cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rsq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_kind     (req.kind),
        .req_task     (req.task_id),
        .req_priority (req.task_priority),
        .cmd          (cmd),
        .stat         (stat),
        .head_task    (rsp.head_task),
        .head_is_idle (rsp.head_is_idle),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy)
    );

endmodule

### design/rsq_checker.sv
// ----------------------------------------------------------------------------
// rsq_checker
// Port-level checks of the run queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_sorted_run_queue_top_macros.svh"

module rsq_checker
    import rsq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    head_is_idle,
    input logic [STATUS_BITS-1:0]  status,
    input logic [OCC_OUT_BITS-1:0] occupancy
);

    `RSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "rsp dropped while stalled")
    `RSQ_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while executing")
    `RSQ_ASSERT_NOW(a_idle_empty, rsp_valid && head_is_idle, occupancy == '0, "idle head with tasks queued")
    `RSQ_ASSERT_NOW(a_full_depth, rsp_valid && (status == STATUS_FULL), occupancy == OCC_OUT_BITS'(QUEUE_DEPTH), "full status below depth")

endmodule

bind priority_sorted_run_queue_top rsq_checker u_rsq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .head_is_idle (rsp.head_is_idle),
    .status       (rsp.status),
    .occupancy    (rsp.occupancy)
);
